// File: rtl/stt_pkg.sv
`timescale 1ns / 1ps
// Shared types and character codes for the scrolling text terminal buffer.
// No dependencies; imported by the channel interfaces, the top level and the testbench.
package stt_pkg;

  // Beat field types, fixed by the channel format
  typedef logic [7:0] byte_t;
  typedef logic [6:0] code_t;
  typedef logic [4:0] row_fld_t;
  typedef logic [5:0] col_fld_t;

  // Display register byte: strobe bit and character codes
  localparam int unsigned READY_BIT = 7;
  localparam code_t CODE_CR       = 7'h0D;
  localparam code_t CODE_PRINT_LO = 7'h20;
  localparam code_t CODE_PRINT_HI = 7'h5F;

  // Input mode codes
  localparam logic MODE_DISPLAY = 1'b0;
  localparam logic MODE_READ    = 1'b1;

  // One result beat as held in the output register
  typedef struct packed {
    logic     accepted;
    code_t    echo_byte;
    col_fld_t cursor_column;
    row_fld_t cursor_line;
    logic     scrolled;
    code_t    cell_code;
  } result_t;

endpackage

// File: rtl/stt_in_if.sv
`timescale 1ns / 1ps
// Input channel of the terminal buffer: valid/ready plus one item's fields.
// Depends on stt_pkg.
interface stt_in_if;
  import stt_pkg::*;

  logic     valid;
  logic     ready;
  logic     mode;
  byte_t    display_byte;
  row_fld_t read_row;
  col_fld_t read_col;

  modport source (output valid, mode, display_byte, read_row, read_col, input ready);
  modport sink   (input valid, mode, display_byte, read_row, read_col, output ready);
endinterface

// File: rtl/stt_out_if.sv
`timescale 1ns / 1ps
// Result channel of the terminal buffer: valid/ready plus one result's fields.
// Depends on stt_pkg.
interface stt_out_if;
  import stt_pkg::*;

  logic     valid;
  logic     ready;
  logic     accepted;
  code_t    echo_byte;
  col_fld_t cursor_column;
  row_fld_t cursor_line;
  logic     scrolled;
  code_t    cell_code;

  modport source (output valid, accepted, echo_byte, cursor_column, cursor_line,
                  scrolled, cell_code, input ready);
  modport sink   (input valid, accepted, echo_byte, cursor_column, cursor_line,
                  scrolled, cell_code, output ready);
endinterface

// File: rtl/stt_screen_ram.sv
`timescale 1ns / 1ps
// Character cell memory: one write port, one read port, registered read data.
// No dependencies.
module stt_screen_ram #(
  parameter int unsigned DEPTH = 960,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 7
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/scrolling_text_terminal_buffer.sv
`timescale 1ns / 1ps
// Top level of the scrolling text terminal buffer: cursor, scroll control, output register.
// Depends on stt_pkg, stt_in_if, stt_out_if and stt_screen_ram.
//
//  channel | dir | fields                                                   | beat when
//  in_ch   | in  | mode, display_byte, read_row, read_col                   | valid & ready
//  out_ch  | out | accepted, echo_byte, cursor_column, cursor_line,         | valid & ready
//          |     | scrolled, cell_code                                      |
//
// A display byte is taken in S_IDLE and its result registered; one that scrolls then holds
// the input in S_SCROLL while the freed row is cleared through the cell memory's write port.
// A cell read passes through S_READ, where the registered memory data is loaded into the
// output register. Scrolling moves a row pointer, never the cells. After reset all
// ROWS*COLUMNS cells (960 by default) are swept to zero before the first beat is taken.
// A stalled result holds the input until the output register can be reloaded.
module scrolling_text_terminal_buffer #(
  parameter int unsigned COLUMNS = 40,
  parameter int unsigned ROWS    = 24
) (
  input  logic       clk,
  input  logic       rst_n,
  stt_in_if.sink     in_ch,
  stt_out_if.source  out_ch
);
  import stt_pkg::*;

  localparam int unsigned DEPTH = COLUMNS * ROWS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned XW    = $clog2(COLUMNS);
  localparam int unsigned YW    = $clog2(ROWS);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_READ, S_SCROLL} state_t;

  state_t          state_r,   state_nxt;
  logic [XW-1:0]   cur_x_r,   cur_x_nxt;
  logic [YW-1:0]   cur_y_r,   cur_y_nxt;
  logic [YW-1:0]   top_r,     top_nxt;     // physical row shown as line 0
  logic [AW-1:0]   cnt_r,     cnt_nxt;     // sweep / row clear position
  logic [AW-1:0]   base_r,    base_nxt;    // first cell of the row being cleared
  logic            oob_r,     oob_nxt;     // pending read fell off the screen
  logic            out_vld_r, out_vld_nxt;
  result_t         res_r,     res_nxt;

  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  code_t           ram_wdata, ram_rdata;

  logic            out_free, in_beat, is_ready_byte, is_cr, is_print, scroll;
  code_t           code;
  logic [XW:0]     x_inc;
  logic [YW:0]     y_wide;
  logic [XW-1:0]   nx;
  logic [YW-1:0]   ny;
  logic            row_ok, col_ok;
  logic [AW-1:0]   cur_addr, rd_addr;

  // line number to physical row of the circular store
  function automatic logic [YW-1:0] phys_row(input logic [YW-1:0] top,
                                             input logic [YW-1:0] line);
    logic [YW:0] sum;
    sum = {1'b0, top} + {1'b0, line};
    if (sum >= (YW+1)'(ROWS)) begin
      sum = sum - (YW+1)'(ROWS);
    end
    return sum[YW-1:0];
  endfunction

  stt_screen_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    ($bits(code_t))
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // handshake
  assign out_free    = !out_vld_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && out_free;
  assign in_beat     = in_ch.valid && in_ch.ready;

  // decode of the display byte and cursor advance
  always_comb begin
    code          = in_ch.display_byte[6:0];
    is_ready_byte = in_ch.display_byte[READY_BIT];
    is_cr         = (code == CODE_CR);
    is_print      = code inside {[CODE_PRINT_LO:CODE_PRINT_HI]};
    x_inc         = {1'b0, cur_x_r} + 1'b1;
    nx            = cur_x_r;
    y_wide        = {1'b0, cur_y_r};
    if (is_cr) begin
      nx     = '0;
      y_wide = {1'b0, cur_y_r} + 1'b1;
    end else if (is_print) begin
      if (x_inc == (XW+1)'(COLUMNS)) begin
        nx     = '0;
        y_wide = {1'b0, cur_y_r} + 1'b1;
      end else begin
        nx = x_inc[XW-1:0];
      end
    end
    scroll = (y_wide == (YW+1)'(ROWS));
    ny     = scroll ? YW'(ROWS - 1) : y_wide[YW-1:0];
  end

  // cell addresses for the cursor write and the requested read
  always_comb begin
    row_ok   = 32'(in_ch.read_row) < ROWS;
    col_ok   = 32'(in_ch.read_col) < COLUMNS;
    cur_addr = AW'(phys_row(top_r, cur_y_r)) * AW'(COLUMNS) + AW'(cur_x_r);
    rd_addr  = AW'(phys_row(top_r, YW'(in_ch.read_row))) * AW'(COLUMNS)
             + AW'(XW'(in_ch.read_col));
  end

  // control sequencer
  always_comb begin
    state_nxt   = state_r;
    cur_x_nxt   = cur_x_r;
    cur_y_nxt   = cur_y_r;
    top_nxt     = top_r;
    cnt_nxt     = cnt_r;
    base_nxt    = base_r;
    oob_nxt     = oob_r;
    out_vld_nxt = out_vld_r;
    res_nxt     = res_r;
    ram_we      = 1'b0;
    ram_waddr   = cur_addr;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = rd_addr;

    if (out_vld_r && out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == AW'(DEPTH - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_beat) begin
          if (in_ch.mode == MODE_READ) begin
            ram_re    = 1'b1;
            oob_nxt   = !(row_ok && col_ok);
            state_nxt = S_READ;
          end else begin
            out_vld_nxt           = 1'b1;
            res_nxt               = '0;
            res_nxt.cursor_column = col_fld_t'(cur_x_r);
            res_nxt.cursor_line   = row_fld_t'(cur_y_r);
            if (is_ready_byte) begin
              res_nxt.accepted      = 1'b1;
              res_nxt.echo_byte     = code;
              res_nxt.cursor_column = col_fld_t'(nx);
              res_nxt.cursor_line   = row_fld_t'(ny);
              res_nxt.scrolled      = scroll;
              cur_x_nxt             = nx;
              cur_y_nxt             = ny;
              if (is_print) begin
                ram_we    = 1'b1;
                ram_wdata = code;
              end
              // old top row becomes the new bottom line; clear it
              if (scroll) begin
                top_nxt   = phys_row(top_r, YW'(1));
                base_nxt  = AW'(top_r) * AW'(COLUMNS);
                cnt_nxt   = '0;
                state_nxt = S_SCROLL;
              end
            end
          end
        end
      end
      S_READ: begin
        if (out_free) begin
          out_vld_nxt           = 1'b1;
          res_nxt               = '0;
          res_nxt.cursor_column = col_fld_t'(cur_x_r);
          res_nxt.cursor_line   = row_fld_t'(cur_y_r);
          res_nxt.cell_code     = oob_r ? '0 : ram_rdata;
          state_nxt             = S_IDLE;
        end
      end
      S_SCROLL: begin
        ram_we    = 1'b1;
        ram_waddr = base_r + cnt_r;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == AW'(COLUMNS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      cur_x_r   <= '0;
      cur_y_r   <= '0;
      top_r     <= '0;
      cnt_r     <= '0;
      base_r    <= '0;
      oob_r     <= 1'b0;
      out_vld_r <= 1'b0;
      res_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      cur_x_r   <= cur_x_nxt;
      cur_y_r   <= cur_y_nxt;
      top_r     <= top_nxt;
      cnt_r     <= cnt_nxt;
      base_r    <= base_nxt;
      oob_r     <= oob_nxt;
      out_vld_r <= out_vld_nxt;
      res_r     <= res_nxt;
    end
  end

  // result channel
  assign out_ch.valid         = out_vld_r;
  assign out_ch.accepted      = res_r.accepted;
  assign out_ch.echo_byte     = res_r.echo_byte;
  assign out_ch.cursor_column = res_r.cursor_column;
  assign out_ch.cursor_line   = res_r.cursor_line;
  assign out_ch.scrolled      = res_r.scrolled;
  assign out_ch.cell_code     = res_r.cell_code;

endmodule

// File: verif/scrolling_text_terminal_buffer_test.sv
`timescale 1ns / 1ps
// Testbench for the scrolling text terminal buffer: directed and random beats,
// a screen scoreboard that predicts each result. Depends on stt_pkg, the channel
// interfaces and the scrolling_text_terminal_buffer RTL.
module scrolling_text_terminal_buffer_test;
  import stt_pkg::*;

  localparam int unsigned COLUMNS        = 40;
  localparam int unsigned ROWS           = 24;
  localparam int unsigned RAND_PER_PHASE = 225;
  localparam int unsigned DRAIN_CYCLES   = 64;
  localparam int unsigned CYCLE_LIMIT    = 300000;
  localparam int unsigned NUM_PHASES     = 4;
  localparam int unsigned MAX_REPORTS    = 10;
  // idle / stall percentages per phase
  localparam int unsigned PHASE_IDLE  [NUM_PHASES] = '{0, 76, 0, 10};
  localparam int unsigned PHASE_STALL [NUM_PHASES] = '{0, 0, 76, 10};

  typedef struct packed {
    logic     mode;
    byte_t    display_byte;
    row_fld_t read_row;
    col_fld_t read_col;
  } term_cmd_t;

  // Screen scoreboard: own copy of the cells and cursor, queue of predicted results
  class screen_scoreboard;
    code_t       cells [ROWS][COLUMNS];
    int unsigned cur_x;
    int unsigned cur_y;
    result_t     predicted_status [$];
    int unsigned mismatches;

    function new();
      foreach (cells[r, c]) cells[r][c] = '0;
      cur_x      = 0;
      cur_y      = 0;
      mismatches = 0;
    endfunction

    // Apply one accepted input beat and queue the result it must produce
    function void accept_cmd(term_cmd_t cmd);
      result_t     res;
      code_t       code;
      int unsigned r;
      int unsigned c;
      res = '0;
      if (cmd.mode == MODE_READ) begin
        if (cmd.read_row < ROWS && cmd.read_col < COLUMNS)
          res.cell_code = cells[cmd.read_row][cmd.read_col];
      end else if (cmd.display_byte[READY_BIT]) begin
        code          = cmd.display_byte[6:0];
        res.accepted  = 1'b1;
        res.echo_byte = code;
        if (code == CODE_CR) begin
          cur_x = 0;
          cur_y++;
        end else if (code >= CODE_PRINT_LO && code <= CODE_PRINT_HI) begin
          cells[cur_y][cur_x] = code;
          cur_x++;
        end
        // wrap past the last column
        if (cur_x >= COLUMNS) begin
          cur_x = 0;
          cur_y++;
        end
        // bottom of screen: shift rows up, blank the last one
        if (cur_y >= ROWS) begin
          for (r = 0; r < ROWS - 1; r++) cells[r] = cells[r + 1];
          for (c = 0; c < COLUMNS; c++) cells[ROWS - 1][c] = '0;
          cur_y        = ROWS - 1;
          res.scrolled = 1'b1;
        end
      end
      res.cursor_column = col_fld_t'(cur_x);
      res.cursor_line   = row_fld_t'(cur_y);
      predicted_status.push_back(res);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (predicted_status.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("check: unexpected result beat acc=%0d echo=%h col=%0d line=%0d scr=%0d cell=%h",
                   got.accepted, got.echo_byte, got.cursor_column, got.cursor_line,
                   got.scrolled, got.cell_code);
        return;
      end
      want = predicted_status.pop_front();
      if (got.accepted !== want.accepted || got.echo_byte !== want.echo_byte ||
          got.cursor_column !== want.cursor_column ||
          got.cursor_line !== want.cursor_line || got.scrolled !== want.scrolled ||
          got.cell_code !== want.cell_code) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("check: expected acc=%0d echo=%h col=%0d line=%0d scr=%0d cell=%h",
                   want.accepted, want.echo_byte, want.cursor_column, want.cursor_line,
                   want.scrolled, want.cell_code);
          $display("check: actual   acc=%0d echo=%h col=%0d line=%0d scr=%0d cell=%h",
                   got.accepted, got.echo_byte, got.cursor_column, got.cursor_line,
                   got.scrolled, got.cell_code);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  stt_in_if  in_ch ();
  stt_out_if out_ch ();

  scrolling_text_terminal_buffer #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  screen_scoreboard sb;
  term_cmd_t        directed_cmds [$];
  int unsigned      cycles = 0;
  int unsigned      idle_pct = 0;
  int unsigned      stall_pct = 0;
  int unsigned      burst_left = 0;
  int unsigned      ready_burst = 0;
  int unsigned      line_left = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Beat monitor: inputs noted before results so a same-edge result still finds its prediction
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sb.accept_cmd('{in_ch.mode, in_ch.display_byte, in_ch.read_row, in_ch.read_col});
      if (out_ch.valid && out_ch.ready)
        sb.check_result('{out_ch.accepted, out_ch.echo_byte, out_ch.cursor_column,
                          out_ch.cursor_line, out_ch.scrolled, out_ch.cell_code});
    end
  end

  // Result-side backpressure, with occasional stall-free stretches
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (ready_burst > 0) begin
        ready_burst--;
        out_ch.ready = 1'b1;
      end else begin
        out_ch.ready = ($urandom_range(99) >= stall_pct);
        if ($urandom_range(31) == 0) ready_burst = $urandom_range(40, 8);
      end
    end
  end

  function automatic term_cmd_t mk_cmd(logic mode, byte_t dbyte, row_fld_t row, col_fld_t col);
    term_cmd_t cmd;
    cmd.mode         = mode;
    cmd.display_byte = dbyte;
    cmd.read_row     = row;
    cmd.read_col     = col;
    return cmd;
  endfunction

  // Mostly text lines (short, or long enough to wrap) ended by CR; reads and noise mixed in
  function automatic term_cmd_t next_random_cmd();
    term_cmd_t   cmd;
    int unsigned pick;
    code_t       code;
    cmd.mode         = MODE_DISPLAY;
    cmd.display_byte = byte_t'($urandom_range(255));
    cmd.read_row     = row_fld_t'($urandom_range(31));
    cmd.read_col     = col_fld_t'($urandom_range(63));
    pick = $urandom_range(99);
    if (pick < 18) begin
      cmd.mode = MODE_READ;
      if (pick >= 12) begin
        cmd.read_row = row_fld_t'(sb.cur_y);
        cmd.read_col = col_fld_t'($urandom_range(COLUMNS - 1));
      end else if (pick >= 6) begin
        cmd.read_row = row_fld_t'($urandom_range(ROWS - 1));
        cmd.read_col = col_fld_t'($urandom_range(COLUMNS - 1));
      end
    end else if (pick < 22) begin
      cmd.display_byte = byte_t'($urandom_range((1 << READY_BIT) - 1));
    end else if (pick < 27) begin
      if ($urandom_range(1))
        code = code_t'($urandom_range(CODE_PRINT_LO - 1));
      else
        code = code_t'($urandom_range(127, CODE_PRINT_HI + 1));
      cmd.display_byte = {1'b1, code};
    end else if (line_left == 0) begin
      cmd.display_byte = {1'b1, CODE_CR};
      line_left = ($urandom_range(4) == 0) ? $urandom_range(85, 38) : $urandom_range(8);
    end else begin
      line_left--;
      cmd.display_byte = {1'b1, code_t'($urandom_range(CODE_PRINT_HI, CODE_PRINT_LO))};
    end
    return cmd;
  endfunction

  // Present one beat from a falling edge and hold it until taken
  task automatic send_cmd(term_cmd_t cmd);
    while (burst_left == 0 && $urandom_range(99) < idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    if (burst_left > 0)
      burst_left--;
    else if ($urandom_range(19) == 0)
      burst_left = $urandom_range(30, 8);
    in_ch.valid        = 1'b1;
    in_ch.mode         = cmd.mode;
    in_ch.display_byte = cmd.display_byte;
    in_ch.read_row     = cmd.read_row;
    in_ch.read_col     = cmd.read_col;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  initial begin
    sb                 = new();
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.mode         = MODE_DISPLAY;
    in_ch.display_byte = '0;
    in_ch.read_row     = '0;
    in_ch.read_col     = '0;

    // Directed: field extremes, not-ready bytes, unprintable codes, range edges, CR, reads
    directed_cmds.push_back(mk_cmd(MODE_READ, '0, '0, '0));
    directed_cmds.push_back(mk_cmd(MODE_DISPLAY, 8'h00, '0, '0));
    directed_cmds.push_back(mk_cmd(MODE_DISPLAY, 8'h7F, 5'h1F, 6'h3F));
    directed_cmds.push_back(mk_cmd(MODE_DISPLAY, 8'h80, '0, '0));
    directed_cmds.push_back(mk_cmd(MODE_DISPLAY, {1'b1, CODE_PRINT_LO - code_t'(1)}, '0, '0));
    directed_cmds.push_back(mk_cmd(MODE_DISPLAY, {1'b1, CODE_PRINT_LO}, '0, '0));
    directed_cmds.push_back(mk_cmd(MODE_DISPLAY, {1'b1, CODE_PRINT_HI}, '0, '0));
    directed_cmds.push_back(mk_cmd(MODE_DISPLAY, {1'b1, CODE_PRINT_HI + code_t'(1)}, '0, '0));
    directed_cmds.push_back(mk_cmd(MODE_DISPLAY, 8'hFF, '0, '0));
    directed_cmds.push_back(mk_cmd(MODE_DISPLAY, 8'hC1, '0, '0));
    directed_cmds.push_back(mk_cmd(MODE_DISPLAY, {1'b1, CODE_CR}, '0, '0));
    directed_cmds.push_back(mk_cmd(MODE_DISPLAY, 8'hC2, '0, '0));
    directed_cmds.push_back(mk_cmd(MODE_READ, 8'hFF, 5'd0, 6'd0));
    directed_cmds.push_back(mk_cmd(MODE_READ, '0, 5'd0, 6'd1));
    directed_cmds.push_back(mk_cmd(MODE_READ, '0, 5'd0, 6'd2));
    directed_cmds.push_back(mk_cmd(MODE_READ, '0, 5'd1, 6'd0));
    directed_cmds.push_back(mk_cmd(MODE_READ, '0, 5'd23, 6'd39));
    directed_cmds.push_back(mk_cmd(MODE_READ, '0, 5'd24, 6'd0));
    directed_cmds.push_back(mk_cmd(MODE_READ, '0, 5'd0, 6'd40));
    directed_cmds.push_back(mk_cmd(MODE_READ, '0, 5'd23, 6'd40));
    directed_cmds.push_back(mk_cmd(MODE_READ, '0, 5'h1F, 6'h3F));
    directed_cmds.push_back(mk_cmd(MODE_DISPLAY, {1'b1, CODE_CR}, '0, '0));

    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_cmds[i]) send_cmd(directed_cmds[i]);

    for (int p = 0; p < NUM_PHASES; p++) begin
      idle_pct  = PHASE_IDLE[p];
      stall_pct = PHASE_STALL[p];
      repeat (RAND_PER_PHASE) send_cmd(next_random_cmd());
    end
    in_ch.valid = 1'b0;

    // Drain, then give stray beats a chance to show up
    while (sb.predicted_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.predicted_status.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
